// ===== src/npnf_pkg.sv =====
// ----------------------------------------------------------------------------
// npnf_pkg
// Shared types, widths and the base-face adjacency rules of the nested
// pixel neighbour finder.
// ----------------------------------------------------------------------------
package npnf_pkg;

   localparam int IDX_W     = 62;
   localparam int ORDER_W   = 5;
   localparam int MAX_ORDER = 29;
   localparam int COORD_W   = MAX_ORDER;
   localparam int FACE_W    = 4;
   localparam int FACES     = 12;

   // step directions, in output order
   typedef enum logic [2:0] {
      DIR_E  = 3'd0,
      DIR_NE = 3'd1,
      DIR_N  = 3'd2,
      DIR_NW = 3'd3,
      DIR_W  = 3'd4,
      DIR_SW = 3'd5,
      DIR_S  = 3'd6,
      DIR_SE = 3'd7
   } dir_type;

   // pixel split into face and in-face coordinates
   typedef struct packed {
      logic                 bad;
      logic [FACE_W-1:0]    face;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } pix_info_type;

   // one neighbour answer
   typedef struct packed {
      logic                 present;
      logic [IDX_W-1:0]     index;
   } nbr_type;

   // face lookup answer
   typedef struct packed {
      logic                 ok;
      logic [FACE_W-1:0]    face;
   } face_rule_type;

   // x step of a direction: +1, 0 or -1
   function automatic logic signed [1:0] step_dx(dir_type d);
      logic signed [1:0] r;
      case (d)
         DIR_E, DIR_NE, DIR_SE: r = 2'sb01;
         DIR_NW, DIR_W, DIR_SW: r = 2'sb11;
         default:               r = 2'sb00;
      endcase
      return r;
   endfunction

   // y step of a direction: +1, 0 or -1
   function automatic logic signed [1:0] step_dy(dir_type d);
      logic signed [1:0] r;
      case (d)
         DIR_NE, DIR_N, DIR_NW: r = 2'sb01;
         DIR_SW, DIR_S, DIR_SE: r = 2'sb11;
         default:               r = 2'sb00;
      endcase
      return r;
   endfunction

   // face reached across an edge or corner of base face f
   function automatic face_rule_type face_across(logic [FACE_W-1:0] f, dir_type d);
      face_rule_type r;
      logic [1:0]    fp1;
      logic [1:0]    fp2;
      logic [1:0]    fp3;
      logic [1:0]    fm1;
      fp1 = 2'(f + 4'd1);
      fp2 = 2'(f + 4'd2);
      fp3 = 2'(f + 4'd3);
      fm1 = 2'(f - 4'd1);
      r.ok   = 1'b1;
      r.face = '0;
      if (f <= 4'd3) begin
         // north polar faces
         case (d)
            DIR_E:   r.face = {2'b00, fp1};
            DIR_N:   r.face = {2'b00, fp3};
            DIR_NE:  r.face = {2'b00, fp2};
            DIR_W:   r.face = 4'(f + 4'd4);
            DIR_S:   r.face = {2'b01, fp1};
            DIR_SW:  r.face = 4'(f + 4'd8);
            default: r.ok   = 1'b0;
         endcase
      end else if (f >= 4'd8) begin
         // south polar faces
         case (d)
            DIR_E:   r.face = {2'b01, fp1};
            DIR_N:   r.face = 4'(f - 4'd4);
            DIR_W:   r.face = {2'b10, fp3};
            DIR_S:   r.face = {2'b10, fp1};
            DIR_SW:  r.face = {2'b10, fp2};
            DIR_NE:  r.face = 4'(f - 4'd8);
            default: r.ok   = 1'b0;
         endcase
      end else begin
         // equatorial faces
         case (d)
            DIR_E:   r.face = 4'(f - 4'd4);
            DIR_N:   r.face = {2'b00, fp3};
            DIR_W:   r.face = {2'b10, fp3};
            DIR_S:   r.face = 4'(f + 4'd4);
            DIR_SE:  r.face = {2'b01, fp1};
            DIR_NW:  r.face = {2'b01, fm1};
            default: r.ok   = 1'b0;
         endcase
      end
      if (!r.ok) begin
         r.face = '0;
      end
      return r;
   endfunction

endpackage

// ===== src/npnf_decode.sv =====
// ----------------------------------------------------------------------------
// npnf_decode
// Splits a nested pixel index into base face and deinterleaved x, y.
// ----------------------------------------------------------------------------
module npnf_decode (
   input  logic [npnf_pkg::IDX_W-1:0]   pixel,
   input  logic [npnf_pkg::ORDER_W-1:0] order,
   output npnf_pkg::pix_info_type       info
);
   import npnf_pkg::*;

   logic [IDX_W-1:0] face_full;

   // face is everything above the low 2*order bits
   assign face_full = pixel >> {order, 1'b0};

   always_comb begin
      info.bad  = (|face_full[IDX_W-1:FACE_W]) || (face_full[FACE_W-1:0] >= FACE_W'(FACES));
      info.face = face_full[FACE_W-1:0];
      // x on even bits, y on odd bits
      for (int i = 0; i < COORD_W; i++) begin
         info.x[i] = (ORDER_W'(i) < order) ? pixel[2*i]   : 1'b0;
         info.y[i] = (ORDER_W'(i) < order) ? pixel[2*i+1] : 1'b0;
      end
   end

endmodule

// ===== src/npnf_step.sv =====
// ----------------------------------------------------------------------------
// npnf_step
// Neighbour of a decoded pixel in one direction: wrap, face change across
// edges and corners, polar pin and swap, and reassembly of the nested index.
// ----------------------------------------------------------------------------
module npnf_step (
   input  npnf_pkg::pix_info_type       info,
   input  npnf_pkg::dir_type            dir,
   input  logic [npnf_pkg::ORDER_W-1:0] order,
   output npnf_pkg::nbr_type            nbr
);
   import npnf_pkg::*;

   logic signed [1:0]  dx;
   logic signed [1:0]  dy;
   logic               dx_pos, dx_neg, dy_pos, dy_neg;
   logic [COORD_W-1:0] mask;
   logic [COORD_W-1:0] nx_wrap, ny_wrap;
   logic [COORD_W-1:0] nx, ny;
   logic               at_r, at_l, at_t, at_b;
   logic               inx, iny, corner, npol, spol;
   face_rule_type      rule_diag, rule_x, rule_y, rule;
   logic               present;
   logic [FACE_W-1:0]  nf;
   logic [IDX_W-1:0]   low_bits;

   assign dx     = step_dx(dir);
   assign dy     = step_dy(dir);
   assign dx_pos = (dx == 2'sb01);
   assign dx_neg = (dx == 2'sb11);
   assign dy_pos = (dy == 2'sb01);
   assign dy_neg = (dy == 2'sb11);

   // side - 1
   assign mask = COORD_W'((( COORD_W+1)'(1) << order) - (COORD_W+1)'(1));

   // wrapped coordinates
   assign nx_wrap = (info.x + {{(COORD_W-2){dx[1]}}, dx}) & mask;
   assign ny_wrap = (info.y + {{(COORD_W-2){dy[1]}}, dy}) & mask;

   // edge flags
   assign at_r   = (info.x == mask);
   assign at_l   = (info.x == '0);
   assign at_t   = (info.y == mask);
   assign at_b   = (info.y == '0);
   assign inx    = !((dx_pos && at_r) || (dx_neg && at_l));
   assign iny    = !((dy_pos && at_t) || (dy_neg && at_b));
   assign corner = (dx != 2'sb00) && (dy != 2'sb00) && (at_r || at_l) && (at_t || at_b);
   assign npol   = (info.face <= 4'd3);
   assign spol   = (info.face >= 4'd8);

   // candidate face rules
   assign rule_diag = face_across(info.face, dir);
   assign rule_x    = face_across(info.face, dx_pos ? DIR_E : DIR_W);
   assign rule_y    = face_across(info.face, dy_pos ? DIR_N : DIR_S);

   // pick rule, then pin and swap on polar faces
   always_comb begin
      present = 1'b0;
      nf      = info.face;
      nx      = nx_wrap;
      ny      = ny_wrap;
      rule    = '0;
      if (!info.bad) begin
         if (inx && iny) begin
            present = 1'b1;
         end else begin
            if (corner) begin
               if (npol || spol) begin
                  rule = rule_diag;
               end
            end else if (!inx && iny) begin
               rule = rule_x;
            end else if (!iny && inx) begin
               rule = rule_y;
            end
            present = rule.ok;
            nf      = rule.face;
            if (rule.ok) begin
               if (npol) begin
                  if (at_r && dx_pos) begin
                     nx = ny_wrap;
                     ny = mask;
                  end else if (at_t && dy_pos) begin
                     nx = mask;
                     ny = nx_wrap;
                  end
               end else if (spol) begin
                  if (at_l && dx_neg) begin
                     nx = ny_wrap;
                     ny = '0;
                  end else if (at_b && dy_neg) begin
                     nx = '0;
                     ny = nx_wrap;
                  end
               end
            end
         end
      end
   end

   // interleave x on even bits, y on odd bits
   always_comb begin
      low_bits = '0;
      for (int i = 0; i < COORD_W; i++) begin
         low_bits[2*i]   = nx[i];
         low_bits[2*i+1] = ny[i];
      end
   end

   assign nbr.present = present;
   assign nbr.index   = present ? ((IDX_W'(nf) << {order, 1'b0}) | low_bits) : '0;

endmodule

// ===== src/nested_pixel_neighbour_finder_core.sv =====
// ----------------------------------------------------------------------------
// nested_pixel_neighbour_finder_core
// Eight nested-grid neighbours of one pixel index, one answer per cycle.
//
//   channel   ports                         handshake
//   request   start, busy, req_*            taken when start && !busy
//   result    rsp_valid, rsp_*              one-cycle strobe, no stall
//   config    csr_wr_en, csr_wr_data        written when csr_wr_en
//
// A request waits in a one-entry holding register, is decoded into face and
// x, y as it moves into the direction counter, and then gives one result per
// cycle, one for each of the eight directions, through the result register.
// Runs of successive requests follow back to back on the single result port,
// as the counter loads the next request in the cycle that it finishes the last.
// Synchronous reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nested_pixel_neighbour_finder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [npnf_pkg::IDX_W-1:0]     req_pixel_index,
   input  logic                           csr_wr_en,
   input  logic [npnf_pkg::ORDER_W-1:0]   csr_wr_data,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_direction,
   output logic                           rsp_present,
   output logic [npnf_pkg::IDX_W-1:0]     rsp_neighbour_index,
   output logic                           rsp_bad_pixel,
   output logic                           rsp_last
);
   import npnf_pkg::*;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic [ORDER_W-1:0] order_eff;
   logic               pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]   pend_pix_ff, pend_pix_in;
   logic               act_ff, act_in;
   dir_type            dir_ff, dir_in;
   pix_info_type       info_ff, info_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_dir_ff, rsp_dir_in;
   logic               rsp_present_ff, rsp_present_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic               rsp_bad_ff, rsp_bad_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               accept, load;
   pix_info_type       decoded;
   nbr_type            nbr;

   // grid order register, clamped on use
   assign order_in  = csr_wr_en ? csr_wr_data : order_ff;
   assign order_eff = (order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_ff;

   // holding register hands over when the counter is free or finishing
   assign load   = pend_valid_ff && (!act_ff || (dir_ff == DIR_SE));
   assign busy   = pend_valid_ff && !load;
   assign accept = start && !busy;

   assign pend_valid_in = accept || (pend_valid_ff && !load);
   assign pend_pix_in   = accept ? req_pixel_index : pend_pix_ff;

   npnf_decode u_decode (
      .pixel (pend_pix_ff),
      .order (order_eff),
      .info  (decoded)
   );

   // direction counter
   always_comb begin
      act_in  = act_ff;
      dir_in  = dir_ff;
      info_in = info_ff;
      if (load) begin
         act_in  = 1'b1;
         dir_in  = DIR_E;
         info_in = decoded;
      end else if (act_ff) begin
         dir_in = dir_type'(dir_ff + 3'd1);
         if (dir_ff == DIR_SE) begin
            act_in = 1'b0;
         end
      end
   end

   npnf_step u_step (
      .info  (info_ff),
      .dir   (dir_ff),
      .order (order_eff),
      .nbr   (nbr)
   );

   // result register
   assign rsp_valid_in   = act_ff;
   assign rsp_dir_in     = dir_ff;
   assign rsp_present_in = nbr.present;
   assign rsp_index_in   = nbr.index;
   assign rsp_bad_in     = info_ff.bad;
   assign rsp_last_in    = (dir_ff == DIR_SE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff      <= '0;
         pend_valid_ff <= 1'b0;
         act_ff        <= 1'b0;
         dir_ff        <= DIR_E;
         rsp_valid_ff  <= 1'b0;
      end else begin
         order_ff      <= order_in;
         pend_valid_ff <= pend_valid_in;
         act_ff        <= act_in;
         dir_ff        <= dir_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_pix_ff    <= pend_pix_in;
      info_ff        <= info_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_present_ff <= rsp_present_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_bad_ff     <= rsp_bad_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_direction       = rsp_dir_ff;
   assign rsp_present         = rsp_present_ff;
   assign rsp_neighbour_index = rsp_index_ff;
   assign rsp_bad_pixel       = rsp_bad_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== src/npnf_checker.sv =====
// ----------------------------------------------------------------------------
// npnf_checker
// Port-level checks on the result sequence of the neighbour finder.
// ----------------------------------------------------------------------------
module npnf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic [2:0]                     rsp_direction,
   input logic                           rsp_present,
   input logic [npnf_pkg::IDX_W-1:0]     rsp_neighbour_index,
   input logic                           rsp_bad_pixel,
   input logic                           rsp_last
);
   import npnf_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // a run continues with the next direction in the next cycle
   a_dir_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && (rsp_direction == 3'($past(rsp_direction) + 3'd1))))
      else $error("result run broken or out of direction order");

   // the bad flag is the same across a run
   a_bad_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_bad_pixel == $past(rsp_bad_pixel)))
      else $error("bad flag changed within a run");

   // a bad pixel never has a neighbour
   a_bad_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_pixel) |-> (!rsp_present && (rsp_neighbour_index == '0)))
      else $error("neighbour reported for bad pixel");

   // last marks the final direction only
   a_last_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_direction == DIR_SE)))
      else $error("last flag on wrong direction");

endmodule

bind nested_pixel_neighbour_finder_core npnf_checker u_npnf_checker (.*);
